// ===== hw/rtl/mwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mwc_pkg;

   localparam int unsigned DataW         = 32;
   localparam int unsigned StateW        = 2 * DataW;
   localparam int unsigned CsrIdxW       = 2;
   localparam int unsigned StatusW       = 2;
   localparam int unsigned MaxDraws      = 256;
   localparam int unsigned DrawCntW      = $clog2(MaxDraws + 1);

   localparam logic [DataW-1:0] BaseMultReset = 32'd4294967118;
   localparam logic [DataW-1:0] SeedHighReset = 32'd0;
   localparam logic [DataW-1:0] SeedLowReset  = 32'd100;
   localparam logic [DataW-1:0] AllOnes       = {DataW{1'b1}};

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BASE_MULT = 2'd0,
      CSR_SEED_HIGH = 2'd1,
      CSR_SEED_LOW  = 2'd2
   } mwc_csr_type;

   typedef enum logic [StatusW-1:0] {
      STAT_OK       = 2'd0,
      STAT_BAD_SEED = 2'd1,
      STAT_BAD_MULT = 2'd2
   } mwc_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_STEP_A,
      ST_STEP_B,
      ST_TEST,
      ST_FINISH
   } mwc_state_type;

   typedef struct packed {
      logic           accept;
      logic           step_first;
      logic           step_second;
      logic           res_load;
      mwc_status_type res_status;
      logic           out_load;
   } mwc_cmd_type;

   typedef struct packed {
      logic seed_ok;
      logic mult_low;
      logic pair_good;
      logic draws_done;
   } mwc_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mwc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface mwc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] multiplier;
   logic        restart;
   logic        last;

   modport source (output valid, output multiplier, output restart, output last,
                   input ready);
   modport sink   (input valid, input multiplier, input restart, input last,
                   output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mwc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface mwc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] initial_carry;
   logic [31:0] initial_value;
   logic [1:0]  status;
   logic        last_word;

   modport source (output valid, output initial_carry, output initial_value,
                   output status, output last_word, input ready);
   modport sink   (input valid, input initial_carry, input initial_value,
                   input status, input last_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mwc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mwc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mwc_pkg::mwc_stat_type stat,
   output mwc_pkg::mwc_cmd_type  cmd
);
   import mwc_pkg::*;

   mwc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (!stat.seed_ok || stat.mult_low) state_in = ST_FINISH;
            else state_in = ST_STEP_A;
         end
         ST_STEP_A: state_in = ST_STEP_B;
         ST_STEP_B: state_in = ST_TEST;
         ST_TEST: begin
            if (stat.pair_good || stat.draws_done) state_in = ST_FINISH;
            else state_in = ST_STEP_A;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.res_status = STAT_OK;
      unique case (state_ff)
         ST_IDLE: cmd.accept = req_valid;
         ST_DISPATCH: begin
            cmd.res_load = 1'b1;
            if (!stat.seed_ok) cmd.res_status = STAT_BAD_SEED;
            else if (stat.mult_low) cmd.res_status = STAT_BAD_MULT;
            else cmd.res_load = 1'b0;
         end
         ST_STEP_A: cmd.step_first = 1'b1;
         ST_STEP_B: cmd.step_second = 1'b1;
         ST_TEST: begin
            if (stat.pair_good) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STAT_OK;
            end else if (stat.draws_done) begin
               // retry budget spent
               cmd.res_load   = 1'b1;
               cmd.res_status = STAT_BAD_SEED;
            end
         end
         ST_FINISH: cmd.out_load = slot_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted word did not start work");
   a_retry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST && !stat.pair_good && !stat.draws_done) |=>
      (state_ff == ST_STEP_A))
      else $error("rejected draw not retried");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("loaded word not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.out_load)
      else $error("waiting word overwritten");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/mwc_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mwc_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  mwc_pkg::mwc_cmd_type          cmd,
   output mwc_pkg::mwc_stat_type         stat,
   input  logic                          csr_write_en,
   input  logic [mwc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mwc_pkg::DataW-1:0]     csr_wdata,
   input  logic [mwc_pkg::DataW-1:0]     req_multiplier,
   input  logic                          req_restart,
   input  logic                          req_last,
   output logic [mwc_pkg::DataW-1:0]     rsp_initial_carry,
   output logic [mwc_pkg::DataW-1:0]     rsp_initial_value,
   output logic [mwc_pkg::StatusW-1:0]   rsp_status,
   output logic                          rsp_last_word
);
   import mwc_pkg::*;

   logic [DataW-1:0]    base_mult_ff, seed_high_ff, seed_low_ff;
   logic [StateW-1:0]   base_state_ff, base_state_in;
   logic                seed_ok_ff, seed_ok_in;
   logic [DrawCntW-1:0] draw_cnt_ff;
   logic [DataW-1:0]    mult_ff, carry_ff;
   logic                last_ff;
   mwc_status_type      res_status_ff;
   logic [DataW-1:0]    out_carry_ff, out_value_ff;
   logic [StatusW-1:0]  out_status_ff;
   logic                out_last_ff;

   logic [StateW-1:0]   step_in;
   logic [StateW-1:0]   carry_prod;
   logic [DataW-1:0]    seed_lim, pair_lim, value_cur;

   // one base step: lo * a + hi
   assign step_in    = {{DataW{1'b0}}, base_state_ff[DataW-1:0]} * {{DataW{1'b0}}, base_mult_ff}
                     + {{DataW{1'b0}}, base_state_ff[StateW-1:DataW]};
   assign carry_prod = {{DataW{1'b0}}, base_state_ff[DataW-1:0]} * {{DataW{1'b0}}, mult_ff};
   assign value_cur  = base_state_ff[DataW-1:0];

   assign seed_lim   = base_mult_ff - DataW'(1);
   assign seed_ok_in = !(({seed_high_ff, seed_low_ff} == '0) ||
                         (seed_high_ff >= seed_lim) || (seed_low_ff == AllOnes));

   assign pair_lim   = mult_ff - DataW'(1);

   assign stat.seed_ok    = seed_ok_ff;
   assign stat.mult_low   = (mult_ff < DataW'(2));
   assign stat.pair_good  = !(((carry_ff == '0) && (value_cur == '0)) ||
                              (carry_ff >= pair_lim) || (value_cur == AllOnes));
   assign stat.draws_done = (draw_cnt_ff == DrawCntW'(MaxDraws));

   always_comb begin
      base_state_in = base_state_ff;
      if (cmd.accept && req_restart) base_state_in = {seed_high_ff, seed_low_ff};
      else if (cmd.step_first || cmd.step_second) base_state_in = step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_mult_ff  <= BaseMultReset;
         seed_high_ff  <= SeedHighReset;
         seed_low_ff   <= SeedLowReset;
         base_state_ff <= {SeedHighReset, SeedLowReset};
         seed_ok_ff    <= 1'b0;
         draw_cnt_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (mwc_csr_type'(csr_index))
               CSR_BASE_MULT: base_mult_ff <= csr_wdata;
               CSR_SEED_HIGH: seed_high_ff <= csr_wdata;
               CSR_SEED_LOW:  seed_low_ff  <= csr_wdata;
               default: ;
            endcase
         end
         base_state_ff <= base_state_in;
         if (cmd.accept && req_restart) seed_ok_ff <= seed_ok_in;
         if (cmd.accept) draw_cnt_ff <= '0;
         else if (cmd.step_second) draw_cnt_ff <= draw_cnt_ff + DrawCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mult_ff <= req_multiplier;
         last_ff <= req_last;
      end
      if (cmd.step_second) carry_ff <= carry_prod[StateW-1:DataW];
      if (cmd.res_load) res_status_ff <= cmd.res_status;
      if (cmd.out_load) begin
         out_status_ff <= StatusW'(res_status_ff);
         out_last_ff   <= last_ff;
         if (res_status_ff == STAT_OK) begin
            out_carry_ff <= carry_ff;
            out_value_ff <= value_cur;
         end else begin
            out_carry_ff <= '0;
            out_value_ff <= '0;
         end
      end
   end

   assign rsp_initial_carry = out_carry_ff;
   assign rsp_initial_value = out_value_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_last_word     = out_last_ff;

`ifndef SYNTHESIS
   a_draw_bound: assert property (@(posedge clock) disable iff (reset)
      draw_cnt_ff <= DrawCntW'(MaxDraws))
      else $error("draw count past its bound");
   a_ok_is_good: assert property (@(posedge clock) disable iff (reset)
      (cmd.res_load && cmd.res_status == STAT_OK) |-> stat.pair_good)
      else $error("ok status on a rejected pair");
   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.step_second |=> (draw_cnt_ff == $past(draw_cnt_ff) + DrawCntW'(1)))
      else $error("draw count did not advance");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/mwc_seed_expander.sv =====
`timescale 1ns / 1ps
`default_nettype none
// seed expander for multiply-with-carry generators
// req_chan carries one word per generator: its multiplier, a restart flag
// that reloads and checks the seed registers first, and a last flag.
// rsp_chan returns one word per request: initial carry, initial value,
// status (ok, bad seed, multiplier below 2) and the copied last flag.
// csr_* writes base multiplier (0), seed high (1) and seed low (2); write
// only while no request is in flight.
// one request at a time: ready is high only while the sequencer is idle.
// a draw passes through two base steps, then the pair test; the
// base step multiplier is the shared unit every draw passes through.
// a rejected draw is followed by a new draw, up to 256 draws; seed or
// multiplier errors are loaded without any draw. the next request is
// taken only once the finished word is loaded into the output register.
// a finished word sits in the output register; while it waits the next
// request is still accepted and worked on, and the sequencer holds its own
// word until the receiver takes the previous one.
// reset restores the register defaults and marks the seed unchecked, so
// every request answers bad seed until one arrives with restart set.
module mwc_seed_expander (
   input  logic                        clock,
   input  logic                        reset,
   mwc_req_if.sink                     req_chan,
   mwc_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_en,
   input  logic [mwc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [mwc_pkg::DataW-1:0]   csr_wdata
);
   import mwc_pkg::*;

   mwc_cmd_type  cmd;
   mwc_stat_type stat;

   mwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mwc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_multiplier    (req_chan.multiplier),
      .req_restart       (req_chan.restart),
      .req_last          (req_chan.last),
      .rsp_initial_carry (rsp_chan.initial_carry),
      .rsp_initial_value (rsp_chan.initial_value),
      .rsp_status        (rsp_chan.status),
      .rsp_last_word     (rsp_chan.last_word)
   );
endmodule
`default_nettype wire

// ===== tb/sv/mwc_seed_expander_test.sv =====
`timescale 1ns / 1ps
module mwc_seed_expander_test;
   import mwc_pkg::*;

   localparam int unsigned IdleLimit = 5000;
   localparam int unsigned HoldCycles = 80;

   typedef struct packed {
      logic [DataW-1:0] carry;
      logic [DataW-1:0] value;
      mwc_status_type   status;
      logic             last;
   } seed_word_type;

   // tracks the base generator and the words it should hand out
   class seed_scoreboard;
      logic [DataW-1:0]  base_mult;
      logic [DataW-1:0]  seed_hi;
      logic [DataW-1:0]  seed_lo;
      logic [StateW-1:0] gen_state;
      bit                seed_valid;
      seed_word_type     pending_words[$];
      int                errors;

      function new();
         base_mult  = BaseMultReset;
         seed_hi    = SeedHighReset;
         seed_lo    = SeedLowReset;
         gen_state  = {SeedHighReset, SeedLowReset};
         seed_valid = 0;
         errors     = 0;
      endfunction

      function void set_reg(mwc_csr_type idx, logic [DataW-1:0] data);
         case (idx)
            CSR_BASE_MULT: base_mult = data;
            CSR_SEED_HIGH: seed_hi = data;
            CSR_SEED_LOW:  seed_lo = data;
            default: ;
         endcase
      endfunction

      function logic [StateW-1:0] base_advance(logic [StateW-1:0] s);
         return {32'd0, s[DataW-1:0]} * {32'd0, base_mult} + {32'd0, s[StateW-1:DataW]};
      endfunction

      function int outstanding();
         return pending_words.size();
      endfunction

      function void note_request(logic [DataW-1:0] m, logic rs, logic lst);
         seed_word_type     w;
         logic [StateW-1:0] prod;
         logic [DataW-1:0]  c;
         logic [DataW-1:0]  v;
         w        = '0;
         w.status = STAT_BAD_SEED;
         w.last   = lst;
         if (rs) begin
            gen_state  = {seed_hi, seed_lo};
            seed_valid = !(gen_state == 0 || seed_hi >= base_mult - 32'd1
                           || seed_lo == AllOnes);
         end
         if (!seed_valid) begin
            w.status = STAT_BAD_SEED;
         end else if (m < 2) begin
            w.status = STAT_BAD_MULT;
         end else begin
            // draw pairs until one is usable, giving up after the retry bound
            for (int n = 0; n < MaxDraws; n++) begin
               gen_state = base_advance(gen_state);
               prod      = {32'd0, gen_state[DataW-1:0]} * {32'd0, m};
               c         = prod[StateW-1:DataW];
               gen_state = base_advance(gen_state);
               v         = gen_state[DataW-1:0];
               if (!((c == 0 && v == 0) || c >= m - 32'd1 || v == AllOnes)) begin
                  w.carry  = c;
                  w.value  = v;
                  w.status = STAT_OK;
                  break;
               end
            end
         end
         pending_words.push_back(w);
      endfunction

      function void check_response(logic [DataW-1:0] c, logic [DataW-1:0] v,
                                   logic [StatusW-1:0] st, logic lst);
         seed_word_type w;
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word carry %h value %h status %0d last %0d",
                     $time, c, v, st, lst);
            return;
         end
         w = pending_words.pop_front();
         if (c !== w.carry) begin
            errors++;
            $display("%0t: initial_carry expected %h actual %h", $time, w.carry, c);
         end
         if (v !== w.value) begin
            errors++;
            $display("%0t: initial_value expected %h actual %h", $time, w.value, v);
         end
         if (st !== w.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, w.status, st);
         end
         if (lst !== w.last) begin
            errors++;
            $display("%0t: last_word expected %0d actual %0d", $time, w.last, lst);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [DataW-1:0]    csr_wdata;
   bit                  idle_on = 1;
   bit                  hold_rsp = 0;
   int unsigned         quiet_cycles = 0;
   seed_scoreboard      sb = new();

   mwc_req_if req_if();
   mwc_rsp_if rsp_if();

   mwc_seed_expander u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_write_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == IdleLimit) begin
         $display("mwc_seed_expander_test: FAIL");
         $finish;
      end
   end

   task automatic send_word(logic [DataW-1:0] m, logic rs, logic lst);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.multiplier <= m;
      req_if.restart    <= rs;
      req_if.last       <= lst;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(m, rs, lst);
   endtask

   // registers only change once every word in flight has come back
   task automatic load_regs(logic [DataW-1:0] bm, logic [DataW-1:0] hi, logic [DataW-1:0] lo);
      mwc_csr_type      order[3] = '{CSR_BASE_MULT, CSR_SEED_HIGH, CSR_SEED_LOW};
      logic [DataW-1:0] vals[3];
      vals = '{bm, hi, lo};
      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      for (int k = 0; k < 3; k++) begin
         csr_write_en <= 1'b1;
         csr_index    <= order[k];
         csr_wdata    <= vals[k];
         @(posedge clock);
         sb.set_reg(order[k], vals[k]);
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(logic [DataW-1:0] bm, logic [DataW-1:0] hi,
                            logic [DataW-1:0] lo, int count);
      logic [DataW-1:0] m;
      logic             rs;
      load_regs(bm, hi, lo);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (i == count / 2 && count >= 100) hold_rsp = 1;
         case ($urandom_range(0, 15))
            0:       m = $urandom_range(0, 3);
            1:       m = AllOnes - $urandom_range(0, 3);
            2:       m = 32'd1 << $urandom_range(0, 31);
            default: m = $urandom;
         endcase
         rs = (i == 0) || ($urandom_range(0, 31) == 0);
         send_word(m, rs, $urandom_range(0, 1));
      end
   endtask

   // receiver: random back-pressure plus one long hold per large phase
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      wait (!reset);
      forever begin
         gap = idle_on ? $urandom_range(0, 6) : 0;
         if (hold_rsp) begin
            gap      = HoldCycles;
            hold_rsp = 0;
         end
         if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         sb.check_response(rsp_if.initial_carry, rsp_if.initial_value,
                           rsp_if.status, rsp_if.last_word);
      end
   end

   initial begin
      logic [DataW-1:0] bm;
      logic [DataW-1:0] hi;
      req_if.valid      <= 1'b0;
      req_if.multiplier <= '0;
      req_if.restart    <= 1'b0;
      req_if.last       <= 1'b0;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_BASE_MULT;
      csr_wdata         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // seed unchecked since reset, bad seed wins over a bad multiplier
      send_word(32'd5, 1'b0, 1'b0);
      send_word(32'd0, 1'b0, 1'b1);
      // default seed is valid once checked
      send_word(32'd7, 1'b1, 1'b0);
      send_word(32'd0, 1'b0, 1'b0);
      send_word(32'd1, 1'b0, 1'b1);
      send_word(32'd2, 1'b0, 1'b0);
      send_word(32'd3, 1'b0, 1'b1);
      send_word(AllOnes, 1'b0, 1'b1);
      send_word(32'h8000_0000, 1'b0, 1'b0);
      send_word(32'hFFFF_FFFE, 1'b0, 1'b0);

      // top base multiplier, seed high just under the limit
      run_phase(AllOnes, 32'hFFFF_FFFD, 32'hFFFF_FFFE, 150);
      // seed high equal to the limit
      run_phase(AllOnes, 32'hFFFF_FFFE, 32'd5, 12);
      // zero seed
      run_phase($urandom | 32'h0000_1000, 32'd0, 32'd0, 12);
      // seed low all ones
      run_phase($urandom | 32'h0000_1000, 32'd1, AllOnes, 12);
      // base multiplier 0 wraps the limit and collapses the generator
      run_phase(32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 6);
      // base multiplier 1 leaves no valid seed high
      run_phase(32'd1, 32'd0, 32'd7, 12);
      run_phase(32'd2, 32'd0, 32'd12345, 150);
      // smallest nonzero seed, seed low zero with seed high set
      run_phase(AllOnes, 32'd0, 32'd1, 75);
      run_phase(32'hFFFF_FFF0, 32'd3, 32'd0, 75);

      for (int p = 0; p < 8; p++) begin
         bm = $urandom;
         while (bm < 2) bm = $urandom;
         hi = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, bm - 2);
         run_phase(bm, hi, $urandom, 170);
      end

      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("mwc_seed_expander_test: PASS");
      end else begin
         $display("mwc_seed_expander_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/mwc_pkg.sv
hw/rtl/mwc_req_if.sv
hw/rtl/mwc_rsp_if.sv
hw/rtl/mwc_ctrl.sv
hw/rtl/mwc_dpath.sv
hw/rtl/mwc_seed_expander.sv
tb/sv/mwc_seed_expander_test.sv
